// File: hdl/btli_pkg.sv
// ----------------------------------------------------------------------------
// btli_pkg: shared constants for the breakpoint table interpolator
// Field widths, default sizes and command codes.
// ----------------------------------------------------------------------------
package btli_pkg;

  localparam int DEF_MAX_POINTS  = 64;
  localparam int DEF_VALUE_WIDTH = 32;

  localparam int TIME_W  = 32;
  localparam int INDEX_W = 6;
  localparam int COUNT_W = 7;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

endpackage

// File: hdl/btli_muldiv.sv
// ----------------------------------------------------------------------------
// btli_muldiv: serial floor(a * b / c)
// Shift-add multiply, then restoring divide, both in one product register.
// Needs b <= c and c > 0.
// ----------------------------------------------------------------------------
module btli_muldiv #(
  parameter int A_W = btli_pkg::DEF_VALUE_WIDTH + 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [A_W-1:0]            a_i,
  input  logic [btli_pkg::TIME_W-1:0] b_i,
  input  logic [btli_pkg::TIME_W-1:0] c_i,
  output logic                      done_o,
  output logic [A_W-1:0]            q_o
);

  localparam int TW    = btli_pkg::TIME_W;
  localparam int P_W   = TW + A_W;
  localparam int MAXN  = (A_W > TW) ? A_W : TW;
  localparam int CNT_W = $clog2(MAXN + 1);

  logic             busy_q, div_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [TW-1:0]    hi_q, b_q, c_q;
  logic [A_W-1:0]   lo_q, a_q;

  logic [P_W-1:0]   prod_nx;
  logic [TW:0]      rem2, diff;
  logic             ge;

  assign prod_nx = {hi_q[TW-2:0], lo_q, 1'b0} + P_W'(b_q[TW-1] ? a_q : '0);

  // remainder stays below c, so the shifted value fits one extra bit
  assign rem2 = {hi_q, lo_q[A_W-1]};
  assign diff = rem2 - {1'b0, c_q};
  assign ge   = (rem2 >= {1'b0, c_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      div_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && div_q && (cnt_q == '0) && !start_i;
      if (start_i) begin
        busy_q <= 1'b1;
        div_q  <= 1'b0;
        cnt_q  <= CNT_W'(TW - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          if (div_q) begin
            busy_q <= 1'b0;
          end else begin
            div_q <= 1'b1;
            cnt_q <= CNT_W'(A_W - 1);
          end
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      b_q  <= b_i;
      c_q  <= c_i;
      hi_q <= '0;
      lo_q <= '0;
    end else if (busy_q) begin
      if (!div_q) begin
        {hi_q, lo_q} <= prod_nx;
        b_q          <= {b_q[TW-2:0], 1'b0};
      end else begin
        hi_q <= ge ? diff[TW-1:0] : rem2[TW-1:0];
        lo_q <= {lo_q[A_W-2:0], ge};
      end
    end
  end

  assign done_o = done_q;
  assign q_o    = lo_q;

endmodule

// File: hdl/breakpoint_table_linear_interpolator.sv
// ----------------------------------------------------------------------------
// breakpoint_table_linear_interpolator: piecewise linear lookup over a table
// Holds up to MAX_POINTS breakpoints of time, current and voltage. Write beats
// load one slot and return nothing; query beats return one result beat.
// ----------------------------------------------------------------------------
// A query walks the table from slot 0 through a single registered read port,
// one FETCH and one CHECK state per breakpoint visited; on a hit the shared
// serial multiply-divide then runs twice (current, then voltage). The
// input is not ready while a query is in progress; the result sits in an
// output register, so the next beat may be taken before it is drained. Table
// slots read back undefined until written, and point_count applies to all
// later queries once written.
module breakpoint_table_linear_interpolator #(
  parameter  int MAX_POINTS  = btli_pkg::DEF_MAX_POINTS,
  parameter  int VALUE_WIDTH = btli_pkg::DEF_VALUE_WIDTH,
  localparam int IN_RAW_W    = btli_pkg::INDEX_W + 2 * btli_pkg::TIME_W + 2 * VALUE_WIDTH,
  localparam int IN_DATA_W   = ((IN_RAW_W + 7) / 8) * 8,
  localparam int OUT_DATA_W  = ((2 * VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration: point_count
  input  logic                         cfg_we_i,
  input  logic [btli_pkg::COUNT_W-1:0] cfg_wdata_i,
  // input beats
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // point_index, point_time, point_current, point_voltage, query_time
  input  logic [IN_DATA_W-1:0]         s_axis_tdata_i,
  // command
  input  logic                         s_axis_tuser_i,
  // result beats
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // current_value, voltage_value
  output logic [OUT_DATA_W-1:0]        m_axis_tdata_o,
  // in_range
  output logic                         m_axis_tuser_o
);

  localparam int TW     = btli_pkg::TIME_W;
  localparam int VW     = VALUE_WIDTH;
  localparam int ADDR_W = $clog2(MAX_POINTS);
  localparam int O_IDX  = 0;
  localparam int O_TIM  = O_IDX + btli_pkg::INDEX_W;
  localparam int O_CUR  = O_TIM + TW;
  localparam int O_VOL  = O_CUR + VW;
  localparam int O_QRY  = O_VOL + VW;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FETCH = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_MD    = 3'd3;
  localparam logic [2:0] ST_RESP  = 3'd4;

  typedef struct packed {
    logic [TW-1:0] tim;
    logic [VW-1:0] cur;
    logic [VW-1:0] vol;
  } entry_t;

  // input field views
  logic [btli_pkg::INDEX_W-1:0] in_idx;
  logic [TW-1:0]                in_qtime;
  entry_t                       in_entry;

  assign in_idx       = s_axis_tdata_i[O_IDX +: btli_pkg::INDEX_W];
  assign in_entry.tim = s_axis_tdata_i[O_TIM +: TW];
  assign in_entry.cur = s_axis_tdata_i[O_CUR +: VW];
  assign in_entry.vol = s_axis_tdata_i[O_VOL +: VW];
  assign in_qtime     = s_axis_tdata_i[O_QRY +: TW];

  logic [btli_pkg::COUNT_W-1:0] point_count_q;
  logic [2:0]                   state_q;
  logic [ADDR_W-1:0]            addr_q, last_q;
  logic [TW-1:0]                qtime_q, dt_q, w_q;
  entry_t                       rd_q, prev_q, left_q, right_q;
  entry_t                       mem [MAX_POINTS];
  logic                         sel_q, start_q, hit_q;
  logic [VW-1:0]                cur_res_q, vol_res_q;
  logic                         m_valid_q;
  logic [OUT_DATA_W-1:0]        m_data_q;
  logic                         m_user_q;

  logic                         in_fire, wr_en, seg_hit;
  logic [31:0]                  n_clip;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign wr_en           = in_fire && (s_axis_tuser_i == btli_pkg::CMD_WRITE)
                           && (32'(in_idx) < 32'(MAX_POINTS));
  assign n_clip = (32'(point_count_q) > 32'(MAX_POINTS)) ? 32'(MAX_POINTS)
                                                         : 32'(point_count_q);
  // segment (addr - 1, addr) encloses the query time
  assign seg_hit = (addr_q != '0) && (prev_q.tim <= qtime_q) && (rd_q.tim >= qtime_q);

  // table memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[ADDR_W'(in_idx)] <= in_entry;
    end
    rd_q <= mem[addr_q];
  end

  // operand for the current run of the shared unit
  logic [VW-1:0] v0, v1;
  logic [VW:0]   v0x, dv, mag, qx, res;
  logic          neg;
  logic [VW:0]   md_q;
  logic          md_done;

  assign v0  = sel_q ? left_q.vol : left_q.cur;
  assign v1  = sel_q ? right_q.vol : right_q.cur;
  assign v0x = {v0[VW-1], v0};
  assign dv  = {v1[VW-1], v1} - v0x;
  assign neg = dv[VW];
  assign mag = neg ? (~dv + 1'b1) : dv;
  // zero-width segment keeps the left value
  assign qx  = (w_q == '0) ? '0 : md_q;
  assign res = neg ? (v0x - qx) : (v0x + qx);

  btli_muldiv #(
    .A_W (VW + 1)
  ) u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .a_i     (mag),
    .b_i     (dt_q),
    .c_i     (w_q),
    .done_o  (md_done),
    .q_o     (md_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= '0;
      state_q       <= ST_IDLE;
      addr_q        <= '0;
      sel_q         <= 1'b0;
      start_q       <= 1'b0;
      m_valid_q     <= 1'b0;
    end else begin
      // first run on a hit, second run once the current is done
      start_q <= ((state_q == ST_CHECK) && seg_hit)
                 || ((state_q == ST_MD) && md_done && !sel_q);
      if (cfg_we_i) begin
        point_count_q <= cfg_wdata_i;
      end
      if ((state_q == ST_RESP) && (!m_valid_q || m_axis_tready_i)) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire && (s_axis_tuser_i == btli_pkg::CMD_QUERY)) begin
            addr_q <= '0;
            if (point_count_q == '0) begin
              state_q <= ST_RESP;
            end else begin
              state_q <= ST_FETCH;
            end
          end
        end
        ST_FETCH: begin
          state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          if (seg_hit) begin
            sel_q   <= 1'b0;
            state_q <= ST_MD;
          end else if (addr_q == last_q) begin
            state_q <= ST_RESP;
          end else begin
            addr_q  <= addr_q + 1'b1;
            state_q <= ST_FETCH;
          end
        end
        ST_MD: begin
          if (md_done) begin
            if (!sel_q) begin
              sel_q <= 1'b1;
            end else begin
              state_q <= ST_RESP;
            end
          end
        end
        ST_RESP: begin
          if (!m_valid_q || m_axis_tready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          qtime_q   <= in_qtime;
          last_q    <= ADDR_W'(n_clip - 32'd1);
          cur_res_q <= '0;
          vol_res_q <= '0;
          hit_q     <= 1'b0;
        end
      end
      ST_CHECK: begin
        prev_q    <= rd_q;
        left_q    <= prev_q;
        right_q   <= rd_q;
        dt_q      <= qtime_q - prev_q.tim;
        w_q       <= rd_q.tim - prev_q.tim;
        if (seg_hit) begin
          hit_q <= 1'b1;
        end else begin
          // off every segment so far: last point's voltage stands
          vol_res_q <= rd_q.vol;
        end
      end
      ST_MD: begin
        if (md_done) begin
          if (!sel_q) begin
            cur_res_q <= res[VW-1:0];
          end else begin
            vol_res_q <= res[VW-1:0];
          end
        end
      end
      ST_RESP: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_data_q <= OUT_DATA_W'({vol_res_q, cur_res_q});
          m_user_q <= hit_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

endmodule
